>>> design/sbsh_pkg.sv
// ----------------------------------------------------------------------------
// sbsh_pkg
// Shared types, constants and round functions for the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sbsh_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [6:0] FILL_LAST = 7'd63;
	localparam logic [6:0] LEN_START = 7'd56;
	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] RND_LAST  = 6'd63;
	localparam logic [63:0] BYTE_BITS = 64'd8;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] data;
		logic       ends;
	} item_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	typedef logic [31:0] word_t;

	function automatic word_t init_hash(input logic [2:0] idx);
		word_t r;
		case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			3'd7: r = 32'h5be0cd19;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [5:0] idx);
		word_t r;
		case (idx)
			6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

>>> design/sha256_byte_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// SHA-256 of a byte stream: input stage, item queue and hashing core.
//
//   channel | handshake           | payload
//   in      | in_valid / in_stall | byte_present, data_byte, end_of_message
//   out     | out_valid/out_stall | digest_w0 .. digest_w7
//
// The core takes one queued byte per cycle while it loads a block; each full
// block then runs its rounds and a fold step, during which no bytes are taken.
// Ending a message pads one byte per cycle up to the block end (a second
// block when fewer than nine bytes remain), runs its rounds and fold, then
// the emit state loads the digest register once the output is free. Reset
// clears the queue and sets the initial hash words. The four-entry queue
// keeps input flowing while the core is busy or a digest waits on out_stall.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        byte_present,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_w0,
	output logic [31:0] digest_w1,
	output logic [31:0] digest_w2,
	output logic [31:0] digest_w3,
	output logic [31:0] digest_w4,
	output logic [31:0] digest_w5,
	output logic [31:0] digest_w6,
	output logic [31:0] digest_w7
);
	import sbsh_pkg::*;

	logic  q_full, q_push, q_pop, q_valid;
	item_t push_item, pop_item;
	word_t digest [8];

	sbsh_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.byte_present   (byte_present),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_item         (push_item)
	);

	sbsh_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (pop_item)
	);

	sbsh_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (pop_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.digest    (digest)
	);

	assign digest_w0 = digest[0];
	assign digest_w1 = digest[1];
	assign digest_w2 = digest[2];
	assign digest_w3 = digest[3];
	assign digest_w4 = digest[4];
	assign digest_w5 = digest[5];
	assign digest_w6 = digest[6];
	assign digest_w7 = digest[7];

endmodule

>>> design/sbsh_front.sv
// ----------------------------------------------------------------------------
// sbsh_front
// Input stage: registers each transaction, drops items that carry neither a
// byte nor an end mark, and pushes the rest into the queue.
// ----------------------------------------------------------------------------
module sbsh_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            byte_present,
	input  logic [7:0]      data_byte,
	input  logic            end_of_message,
	input  logic            q_full,
	output logic            q_push,
	output sbsh_pkg::item_t q_item
);
	import sbsh_pkg::*;

	logic  vld_s1;
	item_t item_s1;
	logic  accept;
	logic  keep;

	assign in_stall = vld_s1 & q_full;
	assign accept   = in_valid & ~in_stall;
	assign keep     = item_s1.has_byte | item_s1.ends;
	assign q_push   = vld_s1 & keep & ~q_full;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (!q_full) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.has_byte <= byte_present;
			item_s1.data     <= data_byte;
			item_s1.ends     <= end_of_message;
		end
	end

endmodule

>>> design/sbsh_fifo.sv
// ----------------------------------------------------------------------------
// sbsh_fifo
// Short item queue between the input stage and the hashing core.
// ----------------------------------------------------------------------------
module sbsh_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sbsh_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            pop_valid,
	output sbsh_pkg::item_t pop_item
);
	import sbsh_pkg::*;

	item_t            mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (cnt_q == (QAW+1)'(QDEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];
	assign do_push   = push & ~full;
	assign do_pop    = pop & pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

>>> design/sbsh_core.sv
// ----------------------------------------------------------------------------
// sbsh_core
// Hashing back end: collects bytes into a 512-bit block shift register,
// runs the 64 rounds one per cycle with a rolling message schedule, pads
// the final block(s) byte by byte and holds the digest for delivery.
// ----------------------------------------------------------------------------
module sbsh_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  sbsh_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output sbsh_pkg::word_t digest [8]
);
	import sbsh_pkg::*;

	state_t       state_q, state_d;
	logic [511:0] blk_q;
	logic [6:0]   fill_q;
	logic [63:0]  len_q;
	word_t        chain_q [8];
	word_t        v_q [8];
	word_t        out_q [8];
	logic [5:0]   rnd_q;
	logic         pad_first_q, extra_q, pad_act_q, pend_end_q, final_q;
	logic         out_vld_q;

	logic         emit_fire;
	logic         ext_now;
	logic [63:0]  len_sh;
	logic [7:0]   pad_byte;
	word_t        t1, t2, w_new, w0;
	word_t        ch, maj;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (q_valid) begin
					if (q_item.has_byte && fill_q == FILL_LAST) state_d = ST_ROUND;
					else if (q_item.ends)                       state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (fill_q == FILL_LAST) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_q == RND_LAST) state_d = ST_FOLD;
			end
			ST_FOLD: begin
				if (final_q)                      state_d = ST_EMIT;
				else if (pend_end_q || pad_act_q) state_d = ST_PAD;
				else                              state_d = ST_LOAD;
			end
			ST_EMIT: begin
				if (!out_vld_q || !out_stall) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop     = 1'b0;
		emit_fire = 1'b0;
		case (state_q)
			ST_LOAD: q_pop     = q_valid;
			ST_EMIT: emit_fire = ~out_vld_q | ~out_stall;
			default: begin
				q_pop     = 1'b0;
				emit_fire = 1'b0;
			end
		endcase
	end

	// padding byte
	assign ext_now  = extra_q | (pad_first_q & (fill_q >= LEN_START));
	assign len_sh   = len_q << {fill_q[2:0], 3'b000};
	assign pad_byte = pad_first_q ? PAD_BYTE :
	                  (ext_now || fill_q < LEN_START) ? 8'h00 : len_sh[63:56];

	// round and schedule
	assign w0    = blk_q[511:480];
	assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1    = v_q[7] + big_sigma1(v_q[4]) + ch + round_k(rnd_q) + w0;
	assign t2    = big_sigma0(v_q[0]) + maj;
	assign w_new = small_sigma1(blk_q[63:32]) + blk_q[223:192]
	             + small_sigma0(blk_q[479:448]) + w0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			fill_q      <= '0;
			len_q       <= '0;
			rnd_q       <= '0;
			pad_first_q <= 1'b0;
			extra_q     <= 1'b0;
			pad_act_q   <= 1'b0;
			pend_end_q  <= 1'b0;
			final_q     <= 1'b0;
			out_vld_q   <= 1'b0;
			for (int i = 0; i < 8; i++) chain_q[i] <= init_hash(3'(i));
		end else begin
			state_q <= state_d;
			if (emit_fire)       out_vld_q <= 1'b1;
			else if (!out_stall) out_vld_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						if (q_item.has_byte) begin
							fill_q <= fill_q + 1'b1;
							len_q  <= len_q + BYTE_BITS;
						end
						if (q_item.ends) begin
							if (q_item.has_byte && fill_q == FILL_LAST) pend_end_q  <= 1'b1;
							else                                        pad_first_q <= 1'b1;
						end
					end
				end
				ST_PAD: begin
					fill_q      <= fill_q + 1'b1;
					pad_first_q <= 1'b0;
					pad_act_q   <= 1'b1;
					extra_q     <= ext_now;
					if (fill_q == FILL_LAST) final_q <= ~ext_now;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
				end
				ST_FOLD: begin
					fill_q      <= '0;
					extra_q     <= 1'b0;
					pend_end_q  <= 1'b0;
					pad_first_q <= pend_end_q;
					for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
				end
				ST_EMIT: begin
					if (emit_fire) begin
						len_q     <= '0;
						final_q   <= 1'b0;
						pad_act_q <= 1'b0;
						for (int i = 0; i < 8; i++) chain_q[i] <= init_hash(3'(i));
					end
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.has_byte) begin
			blk_q <= {blk_q[503:0], q_item.data};
		end else if (state_q == ST_PAD) begin
			blk_q <= {blk_q[503:0], pad_byte};
		end else if (state_q == ST_ROUND) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (state_q != ST_ROUND && state_d == ST_ROUND) begin
			for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
		end else if (state_q == ST_ROUND) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
		if (emit_fire) begin
			for (int i = 0; i < 8; i++) out_q[i] <= chain_q[i];
		end
	end

	assign out_valid = out_vld_q;
	assign digest    = out_q;

	a_round_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> fill_q == 7'd64)
		else $error("rounds started on a partial block");

	a_rnd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_ROUND |-> rnd_q == '0)
		else $error("round counter not parked outside rounds");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_EMIT))
		else $error("digest raised outside emit");

	a_pop_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == ST_LOAD && fill_q < 7'd64)
		else $error("queue popped while block busy");

endmodule

>>> dv/tb_sha256_byte_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher_top
// Self-checking bench for the SHA-256 byte stream hasher. A short table of
// directed transactions (empty message, "abc", ends with and without a byte,
// extreme bytes, idle items) runs first. Random messages follow; most are
// short, and some have lengths on the block and padding boundaries. Every
// accepted item feeds a bit-accurate SHA-256 model held in the bench, and
// each digest on the output channel is checked word by word. The run covers
// three flow-control phases and one long output hold-off that fills the
// input queue.
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher_top;

	localparam int QUIET_LIMIT = 5000;
	localparam int LONG_HOLD   = 400;
	localparam int PHASE_ITEMS = 150;
	localparam int PHASE_MSGS  = 4;
	localparam int TAIL_CYCLES = 300;

	typedef enum logic [1:0] {
		KNOWN_NONE,
		KNOWN_EMPTY,
		KNOWN_ABC
	} known_t;

	typedef struct packed {
		logic       byte_present;
		logic [7:0] data_byte;
		logic       end_of_message;
	} tx_t;

	typedef struct packed {
		tx_t    tx;
		known_t known;
	} row_t;

	localparam logic [255:0] EMPTY_DIGEST =
		256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
	localparam logic [255:0] ABC_DIGEST =
		256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

	localparam row_t DIR_ROWS [0:17] = '{
		'{'{1'b0, 8'h00, 1'b0}, KNOWN_NONE},
		'{'{1'b0, 8'hff, 1'b0}, KNOWN_NONE},
		'{'{1'b0, 8'h00, 1'b1}, KNOWN_EMPTY},
		'{'{1'b1, 8'h61, 1'b0}, KNOWN_NONE},
		'{'{1'b1, 8'h62, 1'b0}, KNOWN_NONE},
		'{'{1'b1, 8'h63, 1'b1}, KNOWN_ABC},
		'{'{1'b0, 8'h5a, 1'b0}, KNOWN_NONE},
		'{'{1'b1, 8'h00, 1'b1}, KNOWN_NONE},
		'{'{1'b1, 8'hff, 1'b1}, KNOWN_NONE},
		'{'{1'b1, 8'h61, 1'b0}, KNOWN_NONE},
		'{'{1'b0, 8'ha5, 1'b0}, KNOWN_NONE},
		'{'{1'b1, 8'h62, 1'b0}, KNOWN_NONE},
		'{'{1'b1, 8'h63, 1'b0}, KNOWN_NONE},
		'{'{1'b0, 8'hff, 1'b1}, KNOWN_ABC},
		'{'{1'b0, 8'hff, 1'b1}, KNOWN_EMPTY},
		'{'{1'b1, 8'hff, 1'b0}, KNOWN_NONE},
		'{'{1'b1, 8'h00, 1'b0}, KNOWN_NONE},
		'{'{1'b1, 8'h80, 1'b1}, KNOWN_NONE}
	};

	localparam logic [31:0] IV_WORDS [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RK [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        byte_present;
	logic [7:0]  data_byte;
	logic        end_of_message;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_w0;
	logic [31:0] digest_w1;
	logic [31:0] digest_w2;
	logic [31:0] digest_w3;
	logic [31:0] digest_w4;
	logic [31:0] digest_w5;
	logic [31:0] digest_w6;
	logic [31:0] digest_w7;

	// hash model state
	logic [7:0]  msg_buf [0:63];
	logic [7:0]  blk_work [0:63];
	int          msg_fill;
	logic [63:0] bit_count;
	logic [31:0] chain [0:7];

	logic [255:0] digest_q [$];
	known_t       cur_known;

	int send_pct;
	int recv_pct;
	bit hold_req;
	int hold_left;
	int quiet_cycles;
	int fail_count;
	int items_sent;
	int msgs_sent;
	int digests_checked;
	int longest_msg;

	sha256_byte_stream_hasher_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.byte_present   (byte_present),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digest_w0      (digest_w0),
		.digest_w1      (digest_w1),
		.digest_w2      (digest_w2),
		.digest_w3      (digest_w3),
		.digest_w4      (digest_w4),
		.digest_w5      (digest_w5),
		.digest_w6      (digest_w6),
		.digest_w7      (digest_w7)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void hash_reset();
		msg_fill  = 0;
		bit_count = 64'd0;
		for (int i = 0; i < 8; i++)
			chain[i] = IV_WORDS[i];
	endfunction

	// one 64-round compression of blk_work into chain
	function automatic void mix_block();
		logic [31:0] w [0:63];
		logic [31:0] v [0:7];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_work[4*i], blk_work[4*i+1], blk_work[4*i+2], blk_work[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endfunction

	function automatic bit absorb_item(input tx_t t, output logic [255:0] dg);
		logic [63:0] total;
		dg = '0;
		if (t.byte_present) begin
			msg_buf[msg_fill] = t.data_byte;
			msg_fill++;
			if (msg_fill == 64) begin
				blk_work  = msg_buf;
				mix_block();
				bit_count = bit_count + 64'd512;
				msg_fill  = 0;
			end
		end
		if (!t.end_of_message)
			return 1'b0;
		total = bit_count + 64'(msg_fill) * 64'd8;
		for (int j = 0; j < 64; j++)
			blk_work[j] = (j < msg_fill) ? msg_buf[j] : 8'h00;
		blk_work[msg_fill] = 8'h80;
		if (msg_fill >= 56) begin
			mix_block();
			for (int j = 0; j < 64; j++)
				blk_work[j] = 8'h00;
		end
		for (int j = 0; j < 8; j++)
			blk_work[56+j] = total[63-8*j -: 8];
		mix_block();
		dg = {chain[0], chain[1], chain[2], chain[3], chain[4], chain[5], chain[6], chain[7]};
		hash_reset();
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < 100)
			$display("%s", msg);
		fail_count++;
	endtask

	always @(posedge clk) begin
		logic [255:0] dg;
		logic [255:0] got;
		logic [255:0] want;
		bit           moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				if (absorb_item({byte_present, data_byte, end_of_message}, dg)) begin
					if (cur_known == KNOWN_EMPTY)
						dg = EMPTY_DIGEST;
					else if (cur_known == KNOWN_ABC)
						dg = ABC_DIGEST;
					digest_q = {digest_q, dg};
				end
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				got = {digest_w0, digest_w1, digest_w2, digest_w3,
					digest_w4, digest_w5, digest_w6, digest_w7};
				if (digest_q.size() == 0) begin
					report_mismatch($sformatf("unexpected digest %064h", got));
				end else begin
					want = digest_q.pop_front();
					digests_checked++;
					for (int i = 0; i < 8; i++)
						if (got[255-32*i -: 32] !== want[255-32*i -: 32])
							report_mismatch($sformatf(
								"mismatch digest_w%0d: got %08h, expected %08h",
								i, got[255-32*i -: 32], want[255-32*i -: 32]));
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
		$display("[sha256_byte_stream_hasher_top] ERROR");
		$finish;
	end

	// output side flow control, with an optional long hold-off
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_pct);
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_tx(input tx_t t, input known_t k);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		byte_present   <= t.byte_present;
		data_byte      <= t.data_byte;
		end_of_message <= t.end_of_message;
		cur_known      <= k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (t.byte_present || t.end_of_message)
			items_sent++;
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(12);
		if (r < 90) begin
			case ($urandom_range(9))
				0: return 55;
				1: return 56;
				2: return 57;
				3: return 63;
				4: return 64;
				5: return 65;
				6: return 119;
				7: return 120;
				8: return 127;
				default: return 128;
			endcase
		end
		return $urandom_range(200, 13);
	endfunction

	task automatic send_message(input int len);
		bit end_with_byte;
		end_with_byte = $urandom_range(1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 5)
				send_tx({1'b0, 8'($urandom_range(255)), 1'b0}, KNOWN_NONE);
			send_tx({1'b1, 8'($urandom_range(255)),
				1'(end_with_byte && i == len - 1)}, KNOWN_NONE);
		end
		if (len == 0 || !end_with_byte)
			send_tx({1'b0, 8'($urandom_range(255)), 1'b1}, KNOWN_NONE);
		msgs_sent++;
		if (len > longest_msg)
			longest_msg = len;
	endtask

	initial begin
		int item_mark;
		int msg_mark;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		byte_present    = 1'b0;
		data_byte       = 8'h00;
		end_of_message  = 1'b0;
		cur_known       = KNOWN_NONE;
		send_pct        = 9;
		recv_pct        = 71;
		hold_req        = 1'b0;
		quiet_cycles    = 0;
		fail_count      = 0;
		items_sent      = 0;
		msgs_sent       = 0;
		digests_checked = 0;
		longest_msg     = 0;
		hash_reset();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < $size(DIR_ROWS); i++)
			send_tx(DIR_ROWS[i].tx, DIR_ROWS[i].known);

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin send_pct = 9;  recv_pct = 71; end
				1: begin send_pct = 71; recv_pct = 9;  end
				default: begin
					send_pct = 0;
					recv_pct = 0;
					hold_req = 1'b1;
				end
			endcase
			item_mark = items_sent;
			msg_mark  = msgs_sent;
			while (items_sent - item_mark < PHASE_ITEMS || msgs_sent - msg_mark < PHASE_MSGS)
				send_message(pick_len());
		end
		in_valid <= 1'b0;

		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d items in %0d messages (longest %0d bytes), %0d digests checked",
			items_sent, msgs_sent, longest_msg, digests_checked);
		$display("three flow-control phases plus one %0d-cycle output hold-off", LONG_HOLD);
		if (fail_count == 0)
			$display("[sha256_byte_stream_hasher_top] OK");
		else
			$display("[sha256_byte_stream_hasher_top] ERROR");
		$finish;
	end

endmodule

>>> sha256_byte_stream_hasher_top.f
design/sbsh_pkg.sv
design/sbsh_front.sv
design/sbsh_fifo.sv
design/sbsh_core.sv
design/sha256_byte_stream_hasher_top.sv
dv/tb_sha256_byte_stream_hasher_top.sv
